// ===== hw/rtl/periodic_timer_table_assert.svh =====
// Assertion macros used by the timer table datapath.
// Each macro takes a label, the clock, the active-low reset, the checked expression and an error message.
`ifndef PERIODIC_TIMER_TABLE_ASSERT_SVH
`define PERIODIC_TIMER_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define PTT_ASSERT(lbl, clk_s, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (prop)) else $error(msg);
`define PTT_NEVER(lbl, clk_s, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PTT_ASSERT(lbl, clk_s, rst_n, prop, msg)
`define PTT_NEVER(lbl, clk_s, rst_n, expr, msg)
`endif
`endif

// ===== hw/rtl/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;
	// Width of the time, period and event data words.
	localparam int TIME_W = 32;
	// Width of the default period register.
	localparam int DPER_W = 31;
	localparam logic [DPER_W-1:0] DEFAULT_PERIOD_RESET = 31'd1000;

	// Operation codes of an input beat.
	localparam logic [1:0] OP_ADD    = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_TICK   = 2'd3;

	// Result kinds.
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_REMOVE = 2'd1;
	localparam logic [1:0] KIND_FIRE   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic clear_all;
		logic scan;
		logic apply;
		logic tick_end;
	} ptt_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic scan_done;
		logic is_tick;
	} ptt_sts_t;
endpackage
`default_nettype wire

// ===== hw/rtl/ptt_ram.sv =====
`default_nettype none
module ptt_ram #(
	parameter int WIDTH = 112,
	parameter int DEPTH = 16
) (
	input  wire logic                                       clk,
	input  wire logic                                       we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                           wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

// ===== hw/rtl/ptt_datapath.sv =====
`default_nettype none
`include "periodic_timer_table_assert.svh"
module ptt_datapath import ptt_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int OWNER_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire ptt_cmd_t              cmd,
	output ptt_sts_t                   sts,
	input  wire logic [1:0]            op,
	input  wire logic [OWNER_BITS-1:0] owner_id,
	input  wire logic [TIME_W-1:0]     period,
	input  wire logic [TIME_W-1:0]     event_word,
	input  wire logic [TIME_W-1:0]     now,
	input  wire logic                  cfg_we,
	input  wire logic [DPER_W-1:0]     cfg_wdata,
	output logic                       strobe,
	output logic [1:0]                 kind,
	output logic                       ok,
	output logic [OWNER_BITS-1:0]      fired_owner,
	output logic [TIME_W-1:0]          fired_data,
	output logic                       last
);
	localparam int CNT_W   = $clog2(TIMER_SLOTS + 1);
	localparam int IDX_W   = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
	localparam int ENTRY_W = OWNER_BITS + 3 * TIME_W;

	// Control registers.
	logic [DPER_W-1:0] dper_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  wr_idx_q;
	logic              rd_v_q;
	logic              found_q;
	logic              hold_vld_q;
	logic              strobe_q;

	// Payload registers.
	logic [1:0]            op_q;
	logic [OWNER_BITS-1:0] owner_q;
	logic [TIME_W-1:0]     per_q;
	logic [TIME_W-1:0]     data_q;
	logic [TIME_W-1:0]     now_q;
	logic [IDX_W-1:0]      rd_slot_q;
	logic [IDX_W-1:0]      found_idx_q;
	logic [TIMER_SLOTS-1:0] pend_q;
	logic [OWNER_BITS-1:0] hold_owner_q;
	logic [TIME_W-1:0]     hold_data_q;
	logic [1:0]            kind_q;
	logic                  ok_q;
	logic [OWNER_BITS-1:0] fowner_q;
	logic [TIME_W-1:0]     fdata_q;
	logic                  last_q;

	// Table memory signals.
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;

	logic [OWNER_BITS-1:0] rd_owner;
	logic [TIME_W-1:0]     rd_period;
	logic [TIME_W-1:0]     rd_data;
	logic [TIME_W-1:0]     rd_expiry;

	logic             issue;
	logic             is_tick;
	logic             keep;
	logic             due;
	logic [TIME_W-1:0] new_exp;
	logic             match;
	logic             owner_zero;
	logic             has_room;
	logic             add_ok;
	logic             rem_ok;
	logic [IDX_W-1:0] apply_idx;
	logic             fire_mid;
	logic             fire_end;

	ptt_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TIMER_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (ram_rdata)
	);

	// Unpack the entry that was read last cycle.
	assign rd_owner  = ram_rdata[ENTRY_W-1 -: OWNER_BITS];
	assign rd_period = ram_rdata[3*TIME_W-1 -: TIME_W];
	assign rd_data   = ram_rdata[2*TIME_W-1 -: TIME_W];
	assign rd_expiry = ram_rdata[TIME_W-1:0];

	// Sweep, search and compaction decisions.
	always_comb begin
		issue      = cmd.scan && (rd_idx_q < count_q);
		is_tick    = (op_q == OP_TICK);
		keep       = cmd.scan && rd_v_q && is_tick && !pend_q[rd_slot_q];
		due        = (now_q >= rd_expiry);
		new_exp    = now_q + rd_period;
		match      = cmd.scan && rd_v_q && !is_tick && !found_q && (rd_owner == owner_q);
		owner_zero = (owner_q == '0);
		has_room   = (count_q < CNT_W'(TIMER_SLOTS));
		add_ok     = cmd.apply && (op_q == OP_ADD) && !owner_zero && (found_q || has_room);
		rem_ok     = cmd.apply && (op_q == OP_REMOVE) && !owner_zero && found_q;
		apply_idx  = found_q ? found_idx_q : count_q[IDX_W-1:0];
		fire_mid   = keep && due && hold_vld_q;
		fire_end   = cmd.tick_end && hold_vld_q;
	end

	// The write port serves both compaction during a tick and an add.
	always_comb begin
		ram_we = add_ok || keep;
		if (keep) begin
			ram_waddr = wr_idx_q[IDX_W-1:0];
			ram_wdata = {rd_owner, rd_period, rd_data, due ? new_exp : rd_expiry};
		end else begin
			ram_waddr = apply_idx;
			ram_wdata = {owner_q, per_q, data_q, now_q + per_q};
		end
	end

	assign sts.scan_done = (rd_idx_q >= count_q) && !rd_v_q;
	assign sts.is_tick   = is_tick;

	// Control state with reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dper_q     <= DEFAULT_PERIOD_RESET;
			count_q    <= '0;
			rd_idx_q   <= '0;
			wr_idx_q   <= '0;
			rd_v_q     <= 1'b0;
			found_q    <= 1'b0;
			hold_vld_q <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				dper_q <= cfg_wdata;
			end
			if (cmd.load) begin
				rd_idx_q   <= '0;
				wr_idx_q   <= '0;
				found_q    <= 1'b0;
				hold_vld_q <= 1'b0;
			end
			rd_v_q <= issue;
			if (issue) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (match) begin
				found_q <= 1'b1;
			end
			if (keep) begin
				wr_idx_q <= wr_idx_q + CNT_W'(1);
				if (due) begin
					hold_vld_q <= 1'b1;
				end
			end
			if (cmd.tick_end) begin
				count_q    <= wr_idx_q;
				hold_vld_q <= 1'b0;
			end
			if (add_ok && !found_q) begin
				count_q <= count_q + CNT_W'(1);
			end
			strobe_q <= cmd.apply || fire_mid || fire_end;
		end
	end

	// Payload registers, pending marks and the result beat.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op;
			owner_q <= owner_id;
			per_q   <= period[TIME_W-1] ? {1'b0, dper_q} : period;
			data_q  <= event_word;
			now_q   <= now;
		end
		if (cmd.clear_all) begin
			pend_q <= '1;
		end
		rd_slot_q <= rd_idx_q[IDX_W-1:0];
		if (match) begin
			found_idx_q <= rd_slot_q;
		end
		if (keep) begin
			pend_q[wr_idx_q[IDX_W-1:0]] <= 1'b0;
			if (due) begin
				hold_owner_q <= rd_owner;
				hold_data_q  <= rd_data;
			end
		end
		if (add_ok) begin
			pend_q[apply_idx] <= 1'b0;
		end
		if (rem_ok) begin
			pend_q[found_idx_q] <= 1'b1;
		end
		if (cmd.apply) begin
			kind_q   <= (op_q == OP_ADD) ? KIND_ADD : KIND_REMOVE;
			ok_q     <= add_ok || rem_ok;
			fowner_q <= '0;
			fdata_q  <= '0;
			last_q   <= 1'b1;
		end else if (fire_mid || fire_end) begin
			kind_q   <= KIND_FIRE;
			ok_q     <= 1'b0;
			fowner_q <= hold_owner_q;
			fdata_q  <= hold_data_q;
			last_q   <= fire_end;
		end
	end

	assign strobe      = strobe_q;
	assign kind        = kind_q;
	assign ok          = ok_q;
	assign fired_owner = fowner_q;
	assign fired_data  = fdata_q;
	assign last        = last_q;

	// Compaction never writes ahead of the read sweep.
	`PTT_NEVER(a_wr_behind_rd, clk, arst_n, wr_idx_q > rd_idx_q, "compaction overtook read sweep")
	// The fill count stays within the table.
	`PTT_NEVER(a_count_range, clk, arst_n, count_q > CNT_W'(TIMER_SLOTS), "entry count overflow")
	// Add and remove answers are single beats; fired beats never carry ok.
	`PTT_ASSERT(a_answer_last, clk, arst_n, strobe_q && kind_q != KIND_FIRE |-> last_q, "answer without last")
	`PTT_ASSERT(a_fire_not_ok, clk, arst_n, strobe_q && kind_q == KIND_FIRE |-> !ok_q, "fired beat with ok")
endmodule
`default_nettype wire

// ===== hw/rtl/ptt_ctrl.sv =====
`default_nettype none
module ptt_ctrl import ptt_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire logic [1:0] op,
	input  wire ptt_sts_t sts,
	output logic          busy,
	output ptt_cmd_t      cmd
);
	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_APPLY = 2'd2;
	localparam logic [1:0] S_TEND  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					unique case (op) inside
						OP_CLEAR: cmd.clear_all = 1'b1;
						OP_ADD, OP_REMOVE, OP_TICK: state_d = S_SCAN;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (sts.scan_done) begin
					state_d = sts.is_tick ? S_TEND : S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_IDLE;
			end
			S_TEND: begin
				cmd.tick_end = 1'b1;
				state_d      = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
endmodule
`default_nettype wire

// ===== hw/rtl/periodic_timer_table.sv =====
// Periodic timer table. A command beat is taken when start is high and busy is low. Add and
// remove sweep the table through its single read port, one slot per cycle, while busy is high,
// and answer with one strobe in the same cycle that busy falls. A tick walks and compacts every
// occupied slot the same way and strobes one beat per due timer, in table order; the beat with
// last set is the final one, and a tick with nothing due gives none. A clear does not raise
// busy and gives no beat.
// Result beats are held for exactly one cycle and cannot be stalled, so the receiver must
// capture every strobe. default_period may be written at any idle cycle through cfg_we.
`default_nettype none
module periodic_timer_table import ptt_pkg::*; #(
	parameter int TIMER_SLOTS = 16,
	parameter int OWNER_BITS  = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [1:0]            op,
	input  wire logic [OWNER_BITS-1:0] owner_id,
	input  wire logic [TIME_W-1:0]     period,
	input  wire logic [TIME_W-1:0]     event_word,
	input  wire logic [TIME_W-1:0]     now,
	input  wire logic                  cfg_we,
	input  wire logic [DPER_W-1:0]     cfg_wdata,
	output logic                       strobe,
	output logic [1:0]                 kind,
	output logic                       ok,
	output logic [OWNER_BITS-1:0]      fired_owner,
	output logic [TIME_W-1:0]          fired_data,
	output logic                       last
);
	ptt_cmd_t cmd;
	ptt_sts_t sts;

	// Sequencer for add, remove, clear and tick.
	ptt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.op     (op),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Table memory, sweep counters and result register.
	ptt_datapath #(
		.TIMER_SLOTS(TIMER_SLOTS),
		.OWNER_BITS (OWNER_BITS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.op          (op),
		.owner_id    (owner_id),
		.period      (period),
		.event_word  (event_word),
		.now         (now),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.strobe      (strobe),
		.kind        (kind),
		.ok          (ok),
		.fired_owner (fired_owner),
		.fired_data  (fired_data),
		.last        (last)
	);
endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import ptt_pkg::*;

	localparam int TIMER_SLOTS  = 16;
	localparam int OWNER_BITS   = 16;
	// Drain margin that covers the longest busy stretch, a full-table sweep.
	localparam int DRAIN_CYCLES = 24;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int POOL_SIZE    = 20;

	// One result beat as it appears on the result ports.
	typedef struct packed {
		logic [1:0]            kind;
		logic                  ok;
		logic [OWNER_BITS-1:0] owner;
		logic [TIME_W-1:0]     data;
		logic                  last;
	} timer_result_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	logic [1:0]            op;
	logic [OWNER_BITS-1:0] owner_id;
	logic [TIME_W-1:0]     period;
	logic [TIME_W-1:0]     event_word;
	logic [TIME_W-1:0]     now;
	logic                  cfg_we;
	logic [DPER_W-1:0]     cfg_wdata;
	logic                  strobe;
	logic [1:0]            kind;
	logic                  ok;
	logic [OWNER_BITS-1:0] fired_owner;
	logic [TIME_W-1:0]     fired_data;
	logic                  last;

	// Shadow copy of the timer table and the default period register.
	logic [DPER_W-1:0]     shadow_default_period;
	int                    shadow_count;
	logic [OWNER_BITS-1:0] shadow_owner  [TIMER_SLOTS];
	logic [TIME_W-1:0]     shadow_period [TIMER_SLOTS];
	logic [TIME_W-1:0]     shadow_data   [TIMER_SLOTS];
	logic [TIME_W-1:0]     shadow_expiry [TIMER_SLOTS];
	logic                  shadow_marked [TIMER_SLOTS];

	timer_result_t         awaited_results[$];
	timer_result_t         oldest_result;
	bit                    mismatch_seen = 1'b0;
	int                    cycle_count = 0;
	int                    burst_left = 0;
	logic [OWNER_BITS-1:0] owner_pool [POOL_SIZE];

	periodic_timer_table #(
		.TIMER_SLOTS(TIMER_SLOTS),
		.OWNER_BITS (OWNER_BITS)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.op         (op),
		.owner_id   (owner_id),
		.period     (period),
		.event_word (event_word),
		.now        (now),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.strobe     (strobe),
		.kind       (kind),
		.ok         (ok),
		.fired_owner(fired_owner),
		.fired_data (fired_data),
		.last       (last)
	);

	always #10 clk = ~clk;

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("periodic_timer_table verification failed");
			$finish;
		end
	end

	function automatic timer_result_t make_result(input logic [1:0] k, input logic good,
			input logic [OWNER_BITS-1:0] own, input logic [TIME_W-1:0] data,
			input logic fin);
		timer_result_t r;
		r.kind  = k;
		r.ok    = good;
		r.owner = own;
		r.data  = data;
		r.last  = fin;
		return r;
	endfunction

	// Appends one result to the tail of the awaited list.
	function automatic void queue_expected(input timer_result_t r);
		awaited_results.insert(awaited_results.size(), r);
	endfunction

	// Slot of a live or marked entry with this owner, or -1.
	function automatic int find_timer(input logic [OWNER_BITS-1:0] own);
		int idx;
		idx = -1;
		for (int i = 0; i < shadow_count; i++)
			if (idx < 0 && shadow_owner[i] == own)
				idx = i;
		return idx;
	endfunction

	// Updates the shadow table for one accepted beat and queues the results it causes.
	function automatic void predict_timer_beat(input logic [1:0] o,
			input logic [OWNER_BITS-1:0] own, input logic [TIME_W-1:0] per_in,
			input logic [TIME_W-1:0] data, input logic [TIME_W-1:0] t);
		int            idx;
		int            w;
		logic [TIME_W-1:0] per;
		timer_result_t held;
		bit            have_held;
		idx = find_timer(own);
		case (o)
			OP_ADD: begin
				per = per_in[TIME_W-1] ? {1'b0, shadow_default_period} : per_in;
				if (own == '0 || (idx < 0 && shadow_count >= TIMER_SLOTS)) begin
					queue_expected(make_result(KIND_ADD, 1'b0, '0, '0, 1'b1));
				end else begin
					if (idx < 0) begin
						idx = shadow_count;
						shadow_count++;
						shadow_owner[idx] = own;
					end
					shadow_period[idx] = per;
					shadow_data[idx]   = data;
					shadow_expiry[idx] = t + per;
					shadow_marked[idx] = 1'b0;
					queue_expected(make_result(KIND_ADD, 1'b1, '0, '0, 1'b1));
				end
			end
			OP_REMOVE: begin
				if (own == '0)
					idx = -1;
				if (idx >= 0)
					shadow_marked[idx] = 1'b1;
				queue_expected(make_result(KIND_REMOVE, idx >= 0, '0, '0, 1'b1));
			end
			OP_CLEAR: begin
				for (int i = 0; i < shadow_count; i++)
					shadow_marked[i] = 1'b1;
			end
			default: begin
				// Drop marked entries first, keeping the order of the rest.
				w = 0;
				for (int i = 0; i < shadow_count; i++) begin
					if (!shadow_marked[i]) begin
						shadow_owner[w]  = shadow_owner[i];
						shadow_period[w] = shadow_period[i];
						shadow_data[w]   = shadow_data[i];
						shadow_expiry[w] = shadow_expiry[i];
						shadow_marked[w] = 1'b0;
						w++;
					end
				end
				shadow_count = w;
				// Fire due entries in table order; the final one carries last.
				have_held = 1'b0;
				for (int i = 0; i < shadow_count; i++) begin
					if (t >= shadow_expiry[i]) begin
						if (have_held)
							queue_expected(held);
						held = make_result(KIND_FIRE, 1'b0, shadow_owner[i], shadow_data[i],
							1'b0);
						have_held = 1'b1;
						shadow_expiry[i] = t + shadow_period[i];
					end
				end
				if (have_held) begin
					held.last = 1'b1;
					queue_expected(held);
				end
			end
		endcase
	endfunction

	// Every result beat is compared with the oldest one awaited.
	always @(posedge clk) begin
		if (arst_n && strobe) begin
			if (awaited_results.size() == 0) begin
				$error("result beat with nothing awaited: kind %0d owner %h", kind, fired_owner);
				mismatch_seen = 1'b1;
			end else begin
				oldest_result = awaited_results.pop_front();
				if (kind !== oldest_result.kind) begin
					$error("kind: expected %0d, actual %0d", oldest_result.kind, kind);
					mismatch_seen = 1'b1;
				end
				if (ok !== oldest_result.ok) begin
					$error("ok: expected %0d, actual %0d", oldest_result.ok, ok);
					mismatch_seen = 1'b1;
				end
				if (fired_owner !== oldest_result.owner) begin
					$error("fired_owner: expected %h, actual %h", oldest_result.owner,
						fired_owner);
					mismatch_seen = 1'b1;
				end
				if (fired_data !== oldest_result.data) begin
					$error("fired_data: expected %h, actual %h", oldest_result.data, fired_data);
					mismatch_seen = 1'b1;
				end
				if (last !== oldest_result.last) begin
					$error("last: expected %0d, actual %0d", oldest_result.last, last);
					mismatch_seen = 1'b1;
				end
			end
		end
	end

	// Sends one command beat. Called at a falling edge, returns at the falling edge after
	// acceptance with start still high.
	task automatic send_beat(input logic [1:0] o, input logic [OWNER_BITS-1:0] own,
			input logic [TIME_W-1:0] per, input logic [TIME_W-1:0] data,
			input logic [TIME_W-1:0] t);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start      <= 1'b1;
		op         <= o;
		owner_id   <= own;
		period     <= per;
		event_word <= data;
		now        <= t;
		do @(posedge clk); while (busy);
		predict_timer_beat(o, own, per, data, t);
		@(negedge clk);
	endtask

	// Holds off new beats until every awaited result is in and the block has settled.
	task automatic wait_for_results();
		start <= 1'b0;
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_default_period(input logic [DPER_W-1:0] value);
		wait_for_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
		shadow_default_period = value;
	endtask

	// Refused owner, default and extreme periods, refresh, marks, clear and wrapping time.
	task automatic test_directed_ops();
		logic [TIME_W-1:0] t0;
		t0 = 32'h0000_1000;
		send_beat(OP_ADD, '0, 32'd5, 32'h1234_5678, t0);
		send_beat(OP_REMOVE, '0, '0, '0, t0);
		send_beat(OP_ADD, 16'hFFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, t0);
		send_beat(OP_ADD, 16'h0001, 32'h8000_0000, 32'h0000_0000, t0);
		send_beat(OP_ADD, 16'h0002, 32'd0, 32'hA5A5_5A5A, t0);
		send_beat(OP_ADD, 16'h0003, 32'd10, 32'h0F0F_F0F0, t0);
		send_beat(OP_TICK, '0, '0, '0, t0 - 1);
		send_beat(OP_TICK, '0, '0, '0, t0);
		send_beat(OP_TICK, '0, '0, '0, t0 + 10);
		// Let everything land before the removal checks.
		wait_for_results();
		send_beat(OP_REMOVE, 16'h0003, '0, '0, t0);
		send_beat(OP_REMOVE, 16'h0003, '0, '0, t0);
		send_beat(OP_REMOVE, 16'h004D, '0, '0, t0);
		send_beat(OP_ADD, 16'h0003, 32'd20, 32'h3333_CCCC, t0 + 10);
		send_beat(OP_REMOVE, 16'h0002, '0, '0, t0);
		send_beat(OP_TICK, '0, '0, '0, t0 + 1000);
		send_beat(OP_CLEAR, '0, '0, '0, t0);
		send_beat(OP_TICK, '0, '0, '0, t0 + 5000);
		// Expiry times that wrap past the top of the time range.
		send_beat(OP_ADD, 16'h5555, 32'hFFFF_FFFF, 32'h5555_AAAA, 32'hFFFF_FF00);
		send_beat(OP_ADD, 16'hAAAA, 32'h7FFF_FFFF, 32'hAAAA_5555, 32'hFFFF_FFF0);
		send_beat(OP_TICK, '0, '0, '0, 32'hFFFF_FFFF);
		send_beat(OP_TICK, '0, '0, '0, 32'h0000_0000);
		send_beat(OP_CLEAR, '0, '0, '0, '0);
		send_beat(OP_TICK, '0, '0, '0, 32'h0000_0001);
	endtask

	// Fills every slot, pushes past full, then fires the whole table at once.
	task automatic test_table_full();
		logic [OWNER_BITS-1:0] own;
		logic [TIME_W-1:0]     t0;
		t0 = $urandom;
		while (shadow_count < TIMER_SLOTS) begin
			do own = OWNER_BITS'($urandom_range(1, 16'hFFFF)); while (find_timer(own) >= 0);
			send_beat(OP_ADD, own, $urandom_range(0, 50), $urandom, t0);
		end
		repeat (3) begin
			do own = OWNER_BITS'($urandom_range(1, 16'hFFFF)); while (find_timer(own) >= 0);
			send_beat(OP_ADD, own, $urandom_range(0, 50), $urandom, t0);
		end
		send_beat(OP_ADD, shadow_owner[$urandom_range(0, TIMER_SLOTS - 1)], 32'd0, $urandom,
			t0);
		send_beat(OP_TICK, '0, $urandom, $urandom, t0 + 60);
		send_beat(OP_REMOVE, shadow_owner[$urandom_range(0, TIMER_SLOTS - 1)], $urandom,
			$urandom, t0);
		send_beat(OP_TICK, '0, $urandom, $urandom, t0 + 200);
		send_beat(OP_CLEAR, '0, $urandom, $urandom, t0);
		send_beat(OP_TICK, '0, $urandom, $urandom, t0 + 300);
	endtask

	// Mixed traffic over a small owner pool so that refreshes, removals and a full table occur.
	task automatic test_random_mix(input int n_items);
		logic [TIME_W-1:0]     clock_now;
		logic [OWNER_BITS-1:0] own;
		logic [TIME_W-1:0]     per;
		int                    pick;
		int                    roll;
		clock_now = $urandom;
		for (int i = 0; i < POOL_SIZE; i++)
			owner_pool[i] = OWNER_BITS'($urandom_range(1, 16'hFFFF));
		for (int k = 0; k < n_items; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 4)
				own = '0;
			else if (roll < 10)
				own = OWNER_BITS'($urandom_range(0, 16'hFFFF));
			else
				own = owner_pool[$urandom_range(0, POOL_SIZE - 1)];
			roll = $urandom_range(0, 99);
			if (roll < 15)
				per = $urandom | 32'h8000_0000;
			else if (roll < 22)
				per = $urandom;
			else
				per = $urandom_range(0, 400);
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				send_beat(OP_ADD, own, per, $urandom, clock_now);
			end else if (pick < 58) begin
				send_beat(OP_REMOVE, own, per, $urandom, clock_now);
			end else if (pick < 62) begin
				send_beat(OP_CLEAR, own, per, $urandom, clock_now);
			end else begin
				clock_now = clock_now + $urandom_range(0, 200);
				send_beat(OP_TICK, own, per, $urandom, clock_now);
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		start      = 1'b0;
		op         = OP_ADD;
		owner_id   = '0;
		period     = '0;
		event_word = '0;
		now        = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = '0;
		shadow_default_period = DEFAULT_PERIOD_RESET;
		shadow_count          = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_directed_ops();
		test_table_full();
		write_default_period('0);
		test_random_mix(48);
		write_default_period({DPER_W{1'b1}});
		test_random_mix(48);
		write_default_period(DPER_W'($urandom));
		test_random_mix(48);
		write_default_period(31'd1);
		test_random_mix(48);

		wait_for_results();
		if (mismatch_seen)
			$display("periodic_timer_table verification failed");
		else
			$display("periodic_timer_table verification clean");
		$finish;
	end
endmodule

// ===== periodic_timer_table.f =====
+incdir+hw/rtl
hw/rtl/ptt_pkg.sv
hw/rtl/ptt_ram.sv
hw/rtl/ptt_datapath.sv
hw/rtl/ptt_ctrl.sv
hw/rtl/periodic_timer_table.sv
dv/testbench.sv
